/* design/efrs_pkg.sv */
// Shared constants, status codes and the booking order function for the
// earliest free resource scheduler. No dependencies.
`default_nettype none
package efrs_pkg;

    localparam int PLATFORMS = 8;
    localparam int SLOTS     = 64;
    localparam int TIME_BITS = 16;
    localparam int ID_BITS   = 16;

    localparam int PLAT_BITS = $clog2(PLATFORMS);
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int NUM_BITS  = 4;
    localparam int ADDR_BITS = PLAT_BITS + SLOT_BITS;
    localparam int WORD_BITS = 2 * TIME_BITS + ID_BITS;

    localparam logic [NUM_BITS-1:0] NUM_RESET = 4'd3;

    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [2:0] ST_ASSIGNED  = 3'd0;
    localparam logic [2:0] ST_NONE_FREE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // True when booking one orders strictly after booking two, compared by
    // arrival, then departure, then owner.
    function automatic logic key_after(
        input logic [TIME_BITS-1:0] a1,
        input logic [TIME_BITS-1:0] d1,
        input logic [ID_BITS-1:0]   o1,
        input logic [TIME_BITS-1:0] a2,
        input logic [TIME_BITS-1:0] d2,
        input logic [ID_BITS-1:0]   o2
    );
        logic r;
        if (a1 != a2)
        begin
            r = a1 > a2;
        end
        else if (d1 != d2)
        begin
            r = d1 > d2;
        end
        else
        begin
            r = o1 > o2;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/earliest_free_resource_scheduler_top.sv */
// Top level of the earliest free resource scheduler: booking memory,
// per-resource summary registers and the request sequencer.
// Depends on efrs_pkg.
`default_nettype none

// A request is taken when start is high and busy is low. Its single result
// appears for one cycle with done high and cannot be held off. An assign
// walks the summary registers of the resources in use, one resource a cycle.
// The number in use is the configured count, capped at eight. An assign's
// result follows the scan, the decide state and the registered done. A query
// reads the chosen resource's bookings through the one read port of the
// booking memory, one slot a cycle. Its result follows the reads, the
// query-done state and the registered done.
// The booking memory needs no clearing after reset: only slots below a
// resource's booking count are read. The configuration channel is always
// ready; the user writes it only while idle; the block does not enforce this.
module earliest_free_resource_scheduler_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [efrs_pkg::NUM_BITS-1:0]   cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            req_type,
    input  wire logic [efrs_pkg::ID_BITS-1:0]    train_id,
    input  wire logic [efrs_pkg::TIME_BITS-1:0]  start_time,
    input  wire logic [efrs_pkg::TIME_BITS-1:0]  end_time,
    input  wire logic [2:0]                      platform_sel,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [2:0]                           platform_out,
    output logic [efrs_pkg::ID_BITS-1:0]         train_out
);

    localparam int TB = efrs_pkg::TIME_BITS;
    localparam int IB = efrs_pkg::ID_BITS;
    localparam int PB = efrs_pkg::PLAT_BITS;
    localparam int CB = efrs_pkg::CNT_BITS;
    localparam int NB = efrs_pkg::NUM_BITS;
    localparam int AB = efrs_pkg::ADDR_BITS;
    localparam int WB = efrs_pkg::WORD_BITS;
    localparam int SB = efrs_pkg::SLOT_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_QUERY  = 3'd3;
    localparam logic [2:0] S_QDONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [NB-1:0] num_reg;
    logic          req_reg;
    logic [IB-1:0] own_reg;
    logic [TB-1:0] t0_reg, t1_reg;
    logic [PB-1:0] sel_reg;
    logic [PB:0]   scan_reg, scan_next;
    logic [PB-1:0] best_reg, best_next;
    logic [TB-1:0] best_end_reg, best_end_next;
    logic [CB-1:0] qidx_reg, qidx_next;
    logic          rdv_reg, rdv_next;
    logic          have_reg, have_next;
    logic [TB-1:0] ba_reg, ba_next, bd_reg, bd_next;
    logic [IB-1:0] bo_reg, bo_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [2:0]    pout_reg, pout_next;
    logic [IB-1:0] tout_reg, tout_next;

    logic [CB-1:0] count_reg    [efrs_pkg::PLATFORMS];
    logic [TB-1:0] last_dep_reg [efrs_pkg::PLATFORMS];
    logic [TB-1:0] top_arr_reg  [efrs_pkg::PLATFORMS];
    logic [IB-1:0] top_own_reg  [efrs_pkg::PLATFORMS];

    logic [WB-1:0] mem [1 << AB];
    logic [WB-1:0] mem_rdata;
    logic [AB-1:0] mem_raddr, mem_waddr;
    logic          mem_we;
    logic          top_we;

    logic          accept;
    logic [NB-1:0] n_eff;
    logic [TB-1:0] scan_end;
    logic [TB-1:0] rd_arr, rd_dep;
    logic [IB-1:0] rd_own;
    logic          issue, hit;

    assign cfg_ready    = 1'b1;
    assign busy         = state_reg != S_IDLE;
    assign accept       = start && !busy;
    assign done         = done_reg;
    assign status       = status_reg;
    assign platform_out = pout_reg;
    assign train_out    = tout_reg;

    assign n_eff = (num_reg > NB'(efrs_pkg::PLATFORMS)) ? NB'(efrs_pkg::PLATFORMS) : num_reg;

    assign scan_end = (count_reg[scan_reg[PB-1:0]] != '0) ? last_dep_reg[scan_reg[PB-1:0]] : '0;

    assign rd_arr = mem_rdata[WB-1 -: TB];
    assign rd_dep = mem_rdata[IB +: TB];
    assign rd_own = mem_rdata[IB-1:0];

    assign issue     = qidx_reg < count_reg[sel_reg];
    assign mem_raddr = {sel_reg, qidx_reg[SB-1:0]};
    assign mem_waddr = {best_reg, count_reg[best_reg][SB-1:0]};
    assign hit = rdv_reg && (rd_arr <= t0_reg) &&
                 (!have_reg || efrs_pkg::key_after(rd_arr, rd_dep, rd_own,
                                                   ba_reg, bd_reg, bo_reg));

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        best_next     = best_reg;
        best_end_next = best_end_reg;
        qidx_next     = qidx_reg;
        rdv_next      = 1'b0;
        have_next     = have_reg;
        ba_next       = ba_reg;
        bd_next       = bd_reg;
        bo_next       = bo_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        pout_next     = pout_reg;
        tout_next     = tout_reg;
        mem_we        = 1'b0;
        top_we        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next     = '0;
                    best_next     = '0;
                    best_end_next = '0;
                    qidx_next     = '0;
                    have_next     = 1'b0;
                    state_next    = (req_type == efrs_pkg::REQ_ASSIGN) ? S_SCAN : S_QUERY;
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= n_eff)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    if (scan_reg == '0 || scan_end < best_end_reg)
                    begin
                        best_next     = scan_reg[PB-1:0];
                        best_end_next = scan_end;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                done_next  = 1'b1;
                pout_next  = '0;
                tout_next  = '0;
                state_next = S_IDLE;
                priority if (n_eff == '0 || best_end_reg > t0_reg)
                begin
                    status_next = efrs_pkg::ST_NONE_FREE;
                end
                else if (count_reg[best_reg] >= CB'(efrs_pkg::SLOTS))
                begin
                    status_next = efrs_pkg::ST_FULL;
                end
                else
                begin
                    mem_we      = 1'b1;
                    top_we      = (count_reg[best_reg] == '0) ||
                                  efrs_pkg::key_after(t0_reg, t1_reg, own_reg,
                                                      top_arr_reg[best_reg],
                                                      last_dep_reg[best_reg],
                                                      top_own_reg[best_reg]);
                    status_next = efrs_pkg::ST_ASSIGNED;
                    pout_next   = 3'(best_reg);
                end
            end
            S_QUERY:
            begin
                if (issue)
                begin
                    rdv_next  = 1'b1;
                    qidx_next = qidx_reg + 1'b1;
                end
                if (hit)
                begin
                    have_next = 1'b1;
                    ba_next   = rd_arr;
                    bd_next   = rd_dep;
                    bo_next   = rd_own;
                end
                if (!issue && !rdv_reg)
                begin
                    state_next = S_QDONE;
                end
            end
            S_QDONE:
            begin
                done_next  = 1'b1;
                pout_next  = '0;
                state_next = S_IDLE;
                if (have_reg && bd_reg >= t0_reg)
                begin
                    status_next = efrs_pkg::ST_FOUND;
                    tout_next   = bo_reg;
                end
                else
                begin
                    status_next = efrs_pkg::ST_NOT_FOUND;
                    tout_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= efrs_pkg::NUM_RESET;
            done_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            for (int i = 0; i < efrs_pkg::PLATFORMS; i++)
            begin
                count_reg[i]    <= '0;
                last_dep_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rdv_reg   <= rdv_next;
            if (cfg_valid && cfg_ready)
            begin
                num_reg <= cfg_data;
            end
            if (mem_we)
            begin
                count_reg[best_reg] <= count_reg[best_reg] + 1'b1;
            end
            if (top_we)
            begin
                last_dep_reg[best_reg] <= t1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            own_reg <= train_id;
            t0_reg  <= start_time;
            t1_reg  <= end_time;
            sel_reg <= PB'(platform_sel);
        end
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        best_end_reg <= best_end_next;
        qidx_reg     <= qidx_next;
        have_reg     <= have_next;
        ba_reg       <= ba_next;
        bd_reg       <= bd_next;
        bo_reg       <= bo_next;
        status_reg   <= status_next;
        pout_reg     <= pout_next;
        tout_reg     <= tout_next;
        if (top_we)
        begin
            top_arr_reg[best_reg] <= t0_reg;
            top_own_reg[best_reg] <= own_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {t0_reg, t1_reg, own_reg};
        end
        mem_rdata <= mem[mem_raddr];
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_assign_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) && !req_reg |=> done && (status == efrs_pkg::ST_ASSIGNED ||
            status == efrs_pkg::ST_NONE_FREE || status == efrs_pkg::ST_FULL))
        else $error("assign request gave a query status");

    a_query_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDONE) |=> done && platform_out == '0 &&
            (status == efrs_pkg::ST_FOUND || status == efrs_pkg::ST_NOT_FOUND))
        else $error("query request gave an assign status");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the earliest free resource scheduler top level.
// Depends on efrs_pkg and earliest_free_resource_scheduler_top; a booking
// predictor in the bench supplies the expected answers, but for typed rows.
module testbench;

    import efrs_pkg::*;

    typedef struct packed {
        logic                 req;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] t0;
        logic [TIME_BITS-1:0] t1;
        logic [2:0]           sel;
    } sched_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         plat;
        logic [ID_BITS-1:0] occupant;
    } sched_res_t;

    typedef struct packed {
        logic                 req;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] t0;
        logic [TIME_BITS-1:0] t1;
        logic [2:0]           sel;
        logic                 typed;
        logic [2:0]           status;
        logic [2:0]           plat;
        logic [ID_BITS-1:0]   occupant;
    } sched_row_t;

    localparam int DIR_ROWS     = 18;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 80;
    localparam int ANS_DEPTH    = 16;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [NUM_BITS-1:0]  cfg_data     = '0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 req_type     = REQ_ASSIGN;
    logic [ID_BITS-1:0]   train_id     = '0;
    logic [TIME_BITS-1:0] start_time   = '0;
    logic [TIME_BITS-1:0] end_time     = '0;
    logic [2:0]           platform_sel = '0;
    logic                 done;
    logic [2:0]           status;
    logic [2:0]           platform_out;
    logic [ID_BITS-1:0]   train_out;

    logic [TIME_BITS-1:0] bk_arr      [PLATFORMS*SLOTS];
    logic [TIME_BITS-1:0] bk_dep      [PLATFORMS*SLOTS];
    logic [ID_BITS-1:0]   bk_own      [PLATFORMS*SLOTS];
    int unsigned          bk_count    [PLATFORMS];
    int unsigned          bk_top      [PLATFORMS];
    logic [TIME_BITS-1:0] bk_last_dep [PLATFORMS];
    logic [NUM_BITS-1:0]  plat_in_use = NUM_RESET;

    sched_res_t awaited_answers [ANS_DEPTH];
    logic [4:0] ans_wr_ptr     = '0;
    logic [4:0] ans_rd_ptr     = '0;
    int         mismatch_count = 0;
    int         stall_cycles   = 0;
    logic       no_idle        = 1'b0;

    earliest_free_resource_scheduler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .train_id     (train_id),
        .start_time   (start_time),
        .end_time     (end_time),
        .platform_sel (platform_sel),
        .done         (done),
        .status       (status),
        .platform_out (platform_out),
        .train_out    (train_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sched_res_t book_or_lookup(input sched_req_t rq);
        sched_res_t           res;
        int unsigned          used;
        int unsigned          best;
        int unsigned          slot;
        int unsigned          top;
        logic [TIME_BITS-1:0] best_end;
        logic [TIME_BITS-1:0] free_at;
        logic                 found;
        logic [WORD_BITS-1:0] best_key;
        logic [WORD_BITS-1:0] cand_key;
        res = '0;
        if (rq.req == REQ_ASSIGN)
        begin
            used = (plat_in_use > PLATFORMS) ? PLATFORMS : plat_in_use;
            best = 0;
            best_end = '0;
            for (int i = 0; i < used; i++)
            begin
                free_at = (bk_count[i] != 0) ? bk_last_dep[i] : '0;
                if (i == 0 || free_at < best_end)
                begin
                    best = i;
                    best_end = free_at;
                end
            end
            if (used == 0 || best_end > rq.t0)
            begin
                res.status = ST_NONE_FREE;
            end
            else if (bk_count[best] >= SLOTS)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                slot = best * SLOTS + bk_count[best];
                top = best * SLOTS + bk_top[best];
                if (bk_count[best] == 0 ||
                    {rq.t0, rq.t1, rq.id} > {bk_arr[top], bk_dep[top], bk_own[top]})
                begin
                    bk_top[best] = bk_count[best];
                    bk_last_dep[best] = rq.t1;
                end
                bk_arr[slot] = rq.t0;
                bk_dep[slot] = rq.t1;
                bk_own[slot] = rq.id;
                bk_count[best]++;
                res.status = ST_ASSIGNED;
                res.plat = best[2:0];
            end
        end
        else
        begin
            res.status = ST_NOT_FOUND;
            found = 1'b0;
            best_key = '0;
            for (int k = 0; k < bk_count[rq.sel]; k++)
            begin
                slot = rq.sel * SLOTS + k;
                cand_key = {bk_arr[slot], bk_dep[slot], bk_own[slot]};
                if (bk_arr[slot] <= rq.t0 && (!found || cand_key > best_key))
                begin
                    found = 1'b1;
                    best_key = cand_key;
                end
            end
            if (found && best_key[ID_BITS +: TIME_BITS] >= rq.t0)
            begin
                res.status = ST_FOUND;
                res.occupant = best_key[ID_BITS-1:0];
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic issue_request(input sched_req_t rq, input logic typed,
                                 input sched_res_t typed_res);
        int         gap;
        sched_res_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= rq.req;
        train_id     <= rq.id;
        start_time   <= rq.t0;
        end_time     <= rq.t1;
        platform_sel <= rq.sel;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = book_or_lookup(rq);
        awaited_answers[ans_wr_ptr[3:0]] = typed ? typed_res : predicted;
        ans_wr_ptr = ans_wr_ptr + 1'b1;
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        while (ans_wr_ptr != ans_rd_ptr || busy) @(negedge clk);
    endtask

    task automatic set_platform_count(input logic [NUM_BITS-1:0] val);
        drain_answers();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        plat_in_use = val;
    endtask

    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && done)
        begin
            if (ans_wr_ptr == ans_rd_ptr)
            begin
                note_mismatch($sformatf("unexpected result, status %0d", status));
            end
            else
            begin
                want = awaited_answers[ans_rd_ptr[3:0]];
                ans_rd_ptr = ans_rd_ptr + 1'b1;
                if (status !== want.status)
                    note_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
                if (platform_out !== want.plat)
                    note_mismatch($sformatf("platform_out %0d, wanted %0d",
                                            platform_out, want.plat));
                if (train_out !== want.occupant)
                    note_mismatch($sformatf("train_out %h, wanted %h",
                                            train_out, want.occupant));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[earliest_free_resource_scheduler_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        sched_row_t          dir_rows [DIR_ROWS];
        logic [NUM_BITS-1:0] cfg_plan [PHASES];
        sched_req_t          rq;
        sched_res_t          typed_res;
        int                  clock_now;
        int                  t_a;
        int                  t_b;
        int                  roll;

        dir_rows = '{
            '{REQ_QUERY,  16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1, ST_NOT_FOUND, 3'd0, 16'h0},
            '{REQ_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, ST_NOT_FOUND, 3'd0, 16'h0},
            '{REQ_ASSIGN, 16'hFFFF, 16'h0000, 16'hFFFF, 3'd0, 1'b1, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_ASSIGN, 16'h0001, 16'h0000, 16'h000A, 3'd0, 1'b1, ST_ASSIGNED,  3'd1, 16'h0},
            '{REQ_ASSIGN, 16'h0002, 16'h0005, 16'h0014, 3'd0, 1'b1, ST_ASSIGNED,  3'd2, 16'h0},
            '{REQ_ASSIGN, 16'h0003, 16'h0000, 16'h0005, 3'd0, 1'b1, ST_NONE_FREE, 3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'hFFFF, 16'h0000, 3'd0, 1'b1, ST_FOUND, 3'd0, 16'hFFFF},
            '{REQ_QUERY,  16'h0000, 16'h000A, 16'h0000, 3'd1, 1'b1, ST_FOUND, 3'd0, 16'h0001},
            '{REQ_QUERY,  16'h0000, 16'h000B, 16'h0000, 3'd1, 1'b1, ST_NOT_FOUND, 3'd0, 16'h0},
            '{REQ_ASSIGN, 16'h0004, 16'h000A, 16'h0003, 3'd0, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_ASSIGN, 16'h0005, 16'h0003, 16'h0003, 3'd0, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_ASSIGN, 16'h0005, 16'h0003, 16'h0003, 3'd0, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'h0003, 16'h0000, 3'd1, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'h0009, 16'h0000, 3'd1, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'h0064, 16'h0000, 3'd5, 1'b1, ST_NOT_FOUND, 3'd0, 16'h0},
            '{REQ_ASSIGN, 16'h0000, 16'hFFFF, 16'h0000, 3'd0, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'h0014, 16'h0000, 3'd2, 1'b0, ST_ASSIGNED,  3'd0, 16'h0},
            '{REQ_QUERY,  16'h0000, 16'h0004, 16'h0000, 3'd2, 1'b0, ST_ASSIGNED,  3'd0, 16'h0}
        };
        cfg_plan = '{4'd0, 4'd15, 4'd8, 4'd5, 4'd1, 4'd2, 4'd9, 4'd4, 4'd6, 4'd7, 4'd3, 4'd8};

        for (int p = 0; p < PLATFORMS; p++)
        begin
            bk_count[p] = 0;
            bk_top[p] = 0;
            bk_last_dep[p] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            rq = '{dir_rows[r].req, dir_rows[r].id, dir_rows[r].t0,
                   dir_rows[r].t1, dir_rows[r].sel};
            typed_res = '{dir_rows[r].status, dir_rows[r].plat, dir_rows[r].occupant};
            issue_request(rq, dir_rows[r].typed, typed_res);
        end

        // Assigns advance a running clock so that most of them find a free
        // resource; queries look at times around that clock.
        clock_now = 100;
        typed_res = '0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_platform_count(cfg_plan[ph]);
            no_idle = (ph % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                rq.id  = ID_BITS'($urandom);
                rq.t1  = TIME_BITS'($urandom);
                rq.sel = 3'($urandom);
                if (roll < 15)
                begin
                    rq.req = 1'($urandom);
                    rq.t0  = TIME_BITS'($urandom);
                end
                else if (roll < 55)
                begin
                    rq.req = REQ_ASSIGN;
                    t_a = clock_now + $urandom_range(0, 40);
                    if (t_a > 16'hFFFF)
                        t_a = 16'hFFFF;
                    if ($urandom_range(0, 19) == 0)
                        t_b = $urandom_range(0, t_a);
                    else
                        t_b = t_a + $urandom_range(0, 300);
                    if (t_b > 16'hFFFF)
                        t_b = 16'hFFFF;
                    clock_now = t_a;
                    rq.t0 = t_a[TIME_BITS-1:0];
                    rq.t1 = t_b[TIME_BITS-1:0];
                end
                else
                begin
                    rq.req = REQ_QUERY;
                    t_a = clock_now + 100 - int'($urandom_range(0, 500));
                    if (t_a < 0)
                        t_a = 0;
                    if (t_a > 16'hFFFF)
                        t_a = 16'hFFFF;
                    rq.t0 = t_a[TIME_BITS-1:0];
                end
                issue_request(rq, 1'b0, typed_res);
            end
        end

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[earliest_free_resource_scheduler_top] OK");
        else
            $display("[earliest_free_resource_scheduler_top] ERROR");
        $finish;
    end

endmodule
